// ----- sv/jvbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and byte classification for the JSON value boundary scanner.
// Depends on nothing; every other file of the block imports it.
package jvbs_pkg;

  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1) + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [1:0] {
    PH_SKIP        = 2'd0,
    PH_COMMA_TAKEN = 2'd1,
    PH_VALUE       = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_SKIPPED    = 3'd0,
    ST_INSIDE     = 3'd1,
    ST_END_INCL   = 3'd2,
    ST_END_BEFORE = 3'd3,
    ST_ERROR      = 3'd4
  } status_t;

  typedef logic signed [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    logic is_ws;
    logic is_comma;
    logic is_colon;
    logic is_quote;
    logic is_bslash;
    logic is_lbrack;
    logic is_rbrack;
    logic is_lbrace;
    logic is_rbrace;
    logic is_num_start;
    logic is_num_cont;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    byte_class_t cls;
  } queue_entry_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    logic        digit;
    digit          = (b >= CH_ZERO) && (b <= CH_NINE);
    c.is_ws        = (b != 8'd0) && (b <= CH_SPACE);
    c.is_comma     = (b == CH_COMMA);
    c.is_colon     = (b == CH_COLON);
    c.is_quote     = (b == CH_QUOTE);
    c.is_bslash    = (b == CH_BSLASH);
    c.is_lbrack    = (b == CH_LBRACK);
    c.is_rbrack    = (b == CH_RBRACK);
    c.is_lbrace    = (b == CH_LBRACE);
    c.is_rbrace    = (b == CH_RBRACE);
    c.is_num_start = digit || (b == CH_MINUS) || (b == CH_DOT);
    c.is_num_cont  = digit || (b == CH_DOT) || (b == CH_LOWER_E) || (b == CH_UPPER_E);
    return c;
  endfunction

endpackage

// ----- sv/jvbs_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies each byte and builds a queue entry.
// Depends on jvbs_pkg.
module jvbs_front import jvbs_pkg::*; (
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   data_byte,
  input  logic         start_scan,
  input  logic         queue_full,
  output logic         push,
  output queue_entry_t push_entry
);

  // Stall is taken from the registered queue level only, so it never looks at valid.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_entry.data  = data_byte;
    push_entry.start = start_scan;
    push_entry.cls   = classify(data_byte);
  end

endmodule

// ----- sv/jvbs_queue.sv -----
`timescale 1ns / 1ps
// Short queue of classified bytes between the front end and the scanner core.
// Depends on jvbs_pkg.
module jvbs_queue import jvbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output queue_entry_t head,
  output logic         empty,
  output logic         full
);

  queue_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/jvbs_back.sv -----
`timescale 1ns / 1ps
// Scanner core: holds the value-tracking state, handles one queued byte per cycle while
// the output is not stalled, and drives the registered output channel. Depends on jvbs_pkg.
module jvbs_back import jvbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  queue_entry_t head,
  input  logic         queue_empty,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   status,
  output logic [7:0]   value_byte,
  output logic         keep,
  output depth_t       brace_depth,
  output depth_t       bracket_depth
);

  phase_t  phase, phase_next;
  depth_t  brace_depth_next, bracket_depth_next;
  logic    inside_string, inside_string_next;
  logic    last_was_backslash, last_was_backslash_next;
  logic    inside_number, inside_number_next;
  logic    quoted_value, quoted_value_next;
  status_t status_next;
  logic    keep_next;

  function automatic logic depth_bad(input logic signed [DEPTH_W:0] d);
    return (d > (DEPTH_W+1)'(MAX_DEPTH)) || (d < -(DEPTH_W+1)'(MAX_DEPTH));
  endfunction

  // The output register is free when empty or when its transaction leaves this cycle.
  assign pop = !queue_empty && (!out_valid || !out_stall);

  always_comb begin
    byte_class_t           c;
    logic                  fresh;
    logic                  first;
    logic                  clear;
    logic                  opener;
    logic                  is_bracket;
    logic signed [DEPTH_W:0] nd;
    c     = head.cls;
    fresh = 1'b0;
    first = 1'b0;
    clear = 1'b0;
    nd    = '0;
    opener     = c.is_lbrack || c.is_lbrace;
    is_bracket = c.is_lbrack || c.is_rbrack;

    phase_next              = phase;
    brace_depth_next        = brace_depth;
    bracket_depth_next      = bracket_depth;
    inside_string_next      = inside_string;
    last_was_backslash_next = last_was_backslash;
    inside_number_next      = inside_number;
    quoted_value_next       = quoted_value;
    if (head.start) begin
      phase_next              = PH_SKIP;
      brace_depth_next        = '0;
      bracket_depth_next      = '0;
      inside_string_next      = 1'b0;
      last_was_backslash_next = 1'b0;
      inside_number_next      = 1'b0;
      quoted_value_next       = 1'b0;
    end
    status_next = ST_INSIDE;
    keep_next   = 1'b0;

    if (phase_next == PH_SKIP && c.is_ws) begin
      status_next = ST_SKIPPED;
    end else if (phase_next == PH_SKIP && c.is_comma) begin
      phase_next  = PH_COMMA_TAKEN;
      status_next = ST_SKIPPED;
    end else if (inside_string_next) begin
      keep_next = 1'b1;
      if (c.is_quote && !last_was_backslash_next) begin
        inside_string_next = 1'b0;
        if (brace_depth_next == '0 && bracket_depth_next == '0) begin
          status_next = ST_END_INCL;
          if (quoted_value_next) begin
            keep_next = 1'b0;
          end
          clear = 1'b1;
        end
      end else begin
        last_was_backslash_next = c.is_bslash;
      end
    end else if (inside_number_next) begin
      if (c.is_num_cont) begin
        keep_next = 1'b1;
      end else begin
        inside_number_next = 1'b0;
        if (brace_depth_next == '0 && bracket_depth_next == '0) begin
          status_next = ST_END_BEFORE;
          clear = 1'b1;
        end else begin
          fresh = 1'b1;
        end
      end
    end else begin
      first = (phase_next != PH_VALUE);
      fresh = 1'b1;
    end

    if (fresh) begin
      phase_next = PH_VALUE;
      if (c.is_lbrack || c.is_rbrack || c.is_lbrace || c.is_rbrace) begin
        nd = is_bracket ? {bracket_depth_next[DEPTH_W-1], bracket_depth_next}
                        : {brace_depth_next[DEPTH_W-1], brace_depth_next};
        nd = opener ? nd + 2'sd1 : nd - 2'sd1;
        if (depth_bad(nd)) begin
          status_next = ST_ERROR;
          clear = 1'b1;
        end else begin
          if (is_bracket) begin
            bracket_depth_next = nd[DEPTH_W-1:0];
          end else begin
            brace_depth_next = nd[DEPTH_W-1:0];
          end
          keep_next = 1'b1;
          if (brace_depth_next == '0 && bracket_depth_next == '0) begin
            status_next = ST_END_INCL;
            clear = 1'b1;
          end
        end
      end else if (c.is_quote) begin
        inside_string_next      = 1'b1;
        last_was_backslash_next = 1'b0;
        if (first) begin
          quoted_value_next = 1'b1;
        end else begin
          keep_next = 1'b1;
        end
      end else if (c.is_num_start) begin
        inside_number_next = 1'b1;
        keep_next = 1'b1;
      end else if (c.is_colon || c.is_comma) begin
        keep_next = 1'b1;
        if (brace_depth_next == '0 && bracket_depth_next == '0) begin
          status_next = ST_END_INCL;
          clear = 1'b1;
        end
      end else begin
        status_next = ST_ERROR;
        keep_next   = 1'b0;
        clear = 1'b1;
      end
    end

    // An end or an error leaves the scanner ready for a new value.
    if (clear) begin
      phase_next              = PH_SKIP;
      brace_depth_next        = '0;
      bracket_depth_next      = '0;
      inside_string_next      = 1'b0;
      last_was_backslash_next = 1'b0;
      inside_number_next      = 1'b0;
      quoted_value_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SKIP;
      brace_depth        <= '0;
      bracket_depth      <= '0;
      inside_string      <= 1'b0;
      last_was_backslash <= 1'b0;
      inside_number      <= 1'b0;
      quoted_value       <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (pop) begin
        phase              <= phase_next;
        brace_depth        <= brace_depth_next;
        bracket_depth      <= bracket_depth_next;
        inside_string      <= inside_string_next;
        last_was_backslash <= last_was_backslash_next;
        inside_number      <= inside_number_next;
        quoted_value       <= quoted_value_next;
        out_valid          <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status     <= status_next;
      keep       <= keep_next;
      value_byte <= keep_next ? head.data : 8'd0;
    end
  end

endmodule

// ----- sv/json_value_boundary_scanner.sv -----
`timescale 1ns / 1ps
// Top level of the JSON value boundary scanner: front end, queue and scanner core.
// Depends on jvbs_pkg, jvbs_front, jvbs_queue and jvbs_back.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall   | data_byte, start_scan
//   output  | out       | out_valid / out_stall | status, value_byte, keep
//
// One byte per cycle while the output is not stalled; each byte gives exactly one output transaction.
// A byte passes through the queue and then through the output register.
// The scanner core updates its depth counters and flags once for each byte that it takes.
// Reset is synchronous and clears the queue, the scanner state and the output valid.
// in_stall rises only when the four-entry queue is full; the core stops while out_stall holds a valid output.
module json_value_boundary_scanner import jvbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       start_scan,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] value_byte,
  output logic       keep
);

  logic         push;
  logic         pop;
  logic         queue_empty;
  logic         queue_full;
  queue_entry_t push_entry;
  queue_entry_t head;
  depth_t       brace_depth;
  depth_t       bracket_depth;

  jvbs_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .start_scan (start_scan),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  jvbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty),
    .full       (queue_full)
  );

  jvbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .queue_empty   (queue_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .value_byte    (value_byte),
    .keep          (keep),
    .brace_depth   (brace_depth),
    .bracket_depth (bracket_depth)
  );

  // A byte that is not kept is echoed as zero.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !keep |-> value_byte == 8'd0)
    else $error("value_byte nonzero on a byte that is not kept");

  // Skipped leading bytes never belong to the value text.
  a_skip_no_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SKIPPED |-> !keep)
    else $error("skipped byte marked as kept");

  // Depths stay within the configured limit.
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    brace_depth <= depth_t'(MAX_DEPTH) && brace_depth >= -depth_t'(MAX_DEPTH) &&
    bracket_depth <= depth_t'(MAX_DEPTH) && bracket_depth >= -depth_t'(MAX_DEPTH))
    else $error("depth counter out of range");

  // A finished value or an error leaves both depths at zero for the next scan.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    pop && (u_back.status_next == ST_END_INCL || u_back.status_next == ST_ERROR)
    |=> brace_depth == '0 && bracket_depth == '0)
    else $error("depths not cleared after an end or an error");

endmodule
